@@ rtl/hcbp_pkg.sv @@
package hcbp_pkg;

  localparam int BYTE_W   = 8;
  localparam int SYM_W    = 8;
  localparam int CODE_W   = 32;
  localparam int LEN_IN_W = 6;
  localparam int VBITS_W  = 4;
  localparam int TOTAL_W  = 32;
  localparam int PEND_W   = 7;
  localparam int PCNT_W   = 3;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [SYM_W-1:0]    symbol;
    logic [CODE_W-1:0]   code_bits;
    logic [LEN_IN_W-1:0] code_length;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  packed_byte;
    logic [VBITS_W-1:0] valid_bits;
    logic               last_of_run;
    logic [TOTAL_W-1:0] total_bits;
  } result_t;

endpackage

@@ rtl/hcbp_ifs.sv @@
interface hcbp_item_if;
  import hcbp_pkg::*;

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hcbp_result_if;
  import hcbp_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/hcbp_code_table.sv @@
module hcbp_code_table #(
  parameter int NUM_SYMBOLS = 256,
  parameter int LEN_W       = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [$clog2(NUM_SYMBOLS)-1:0]    wr_addr,
  input  logic [hcbp_pkg::CODE_W-1:0]       wr_code,
  input  logic [LEN_W-1:0]                  wr_len,
  input  logic                              rd_en,
  input  logic [$clog2(NUM_SYMBOLS)-1:0]    rd_addr,
  output logic [hcbp_pkg::CODE_W-1:0]       rd_code,
  output logic [LEN_W-1:0]                  rd_len
);
  import hcbp_pkg::*;

  logic [CODE_W-1:0]      code_mem [NUM_SYMBOLS];
  logic [LEN_W-1:0]       len_mem  [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] written;
  logic                   rd_written;
  logic [LEN_W-1:0]       rd_len_raw;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[wr_addr] <= wr_code;
      len_mem[wr_addr]  <= wr_len;
    end
    if (rd_en) begin
      rd_code    <= code_mem[rd_addr];
      rd_len_raw <= len_mem[rd_addr];
    end
  end

  // entries never loaded read as length zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  assign rd_len = rd_written ? rd_len_raw : '0;

endmodule

@@ rtl/huffman_code_bit_packer.sv @@
// Huffman encoder with an MSB-first byte packer. Load words write one code
// table entry (code right-aligned, length saturated to MAX_CODE_LEN), encode
// words append the symbol's code to the bit accumulator, and flush words push
// out a partial byte padded with zeros. The table is ready right after reset;
// unloaded entries act as length zero and produce nothing. A new input word is
// taken every cycle as long as each word yields at most one output byte and
// the output is not stalled; the single byte emitter sends one byte per cycle
// while the output is taken, so an encode that completes more than one byte
// holds the input until all its bytes are sent. From input acceptance a word
// passes the table read, pack and output registers before reaching the output.
module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN = 32,
  parameter int NUM_SYMBOLS  = 256
) (
  input  logic          clk,
  input  logic          rst,
  hcbp_item_if.sink     item,
  hcbp_result_if.source result
);
  import hcbp_pkg::*;

  localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
  localparam int IDX_W   = $clog2(NUM_SYMBOLS);
  localparam int ACC_W   = PEND_W + MAX_CODE_LEN;
  localparam int SLOTS   = ACC_W / BYTE_W;
  localparam int SR_W    = SLOTS * BYTE_W;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int SHIFT_W = $clog2(ACC_W + 1);

  // input decode
  logic             in_acc;
  logic             sym_ok;
  logic             is_load;
  logic             is_enc;
  logic             is_flush;
  logic             a_take;
  logic [LEN_W-1:0] load_len;

  // stage a
  logic              a_valid;
  logic              a_flush;
  logic              a_go;
  logic [CODE_W-1:0] rd_code;
  logic [LEN_W-1:0]  rd_len;

  // pack state
  logic [PEND_W-1:0]  pend_l;
  logic [PCNT_W-1:0]  pcount;
  logic [TOTAL_W-1:0] bit_total;

  // pack logic
  logic [ACC_W-1:0]   code_m;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   acc_rest;
  logic [SHIFT_W-1:0] tot;
  logic [CNT_W-1:0]   enc_cnt;
  logic [SR_W-1:0]    enc_sr;
  logic [PEND_W-1:0]  enc_pend;
  logic [CNT_W-1:0]   flush_cnt;
  logic [SR_W-1:0]    flush_sr;
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] bit_total_next;

  // byte emitter
  logic [CNT_W-1:0]   cnt;
  logic [SR_W-1:0]    sr;
  logic [VBITS_W-1:0] b_vbits;
  logic               emit;
  logic               b_free;

  // output register
  logic    o_valid;
  result_t o_data;

  assign in_acc   = item.valid && item.ready;
  assign sym_ok   = {1'b0, item.data.symbol} < (SYM_W + 1)'(NUM_SYMBOLS);
  assign is_load  = item.data.cmd == CMD_LOAD;
  assign is_enc   = item.data.cmd == CMD_ENCODE;
  assign is_flush = item.data.cmd == CMD_FLUSH;
  assign a_take   = in_acc && ((is_enc && sym_ok) || is_flush);
  assign load_len = ((LEN_IN_W + 1)'(item.data.code_length) > (LEN_IN_W + 1)'(MAX_CODE_LEN))
                  ? LEN_W'(MAX_CODE_LEN) : LEN_W'(item.data.code_length);

  assign item.ready = !a_valid || a_go;

  hcbp_code_table #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .LEN_W       (LEN_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_acc && is_load && sym_ok),
    .wr_addr (item.data.symbol[IDX_W-1:0]),
    .wr_code (item.data.code_bits),
    .wr_len  (load_len),
    .rd_en   (in_acc && is_enc && sym_ok),
    .rd_addr (item.data.symbol[IDX_W-1:0]),
    .rd_code (rd_code),
    .rd_len  (rd_len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item.ready) begin
      a_valid <= a_take;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && a_take) begin
      a_flush <= is_flush;
    end
  end

  // left-aligned accumulator: pending bits on top, code right below
  always_comb begin
    code_m    = ACC_W'(rd_code) & ~({ACC_W{1'b1}} << rd_len);
    tot       = SHIFT_W'(pcount) + SHIFT_W'(rd_len);
    acc       = {pend_l, (ACC_W - PEND_W)'(0)} | (code_m << (SHIFT_W'(ACC_W) - tot));
    enc_cnt   = CNT_W'(tot >> 3);
    enc_sr    = acc[ACC_W-1 -: SR_W];
    acc_rest  = acc << (tot - SHIFT_W'(tot[2:0]));
    enc_pend  = acc_rest[ACC_W-1 -: PEND_W];
    flush_cnt = (pcount != '0) ? CNT_W'(1) : '0;
    flush_sr  = {pend_l, (SR_W - PEND_W)'(0)};
    total_sum = {1'b0, bit_total} + (TOTAL_W + 1)'(rd_len);
    bit_total_next = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
  end

  assign emit   = (cnt != '0) && (!o_valid || result.ready);
  assign b_free = (cnt == '0) || ((cnt == CNT_W'(1)) && emit);
  assign a_go   = a_valid && b_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_l    <= '0;
      pcount    <= '0;
      bit_total <= '0;
      cnt       <= '0;
    end else begin
      if (a_go) begin
        if (a_flush) begin
          pend_l <= '0;
          pcount <= '0;
          cnt    <= flush_cnt;
        end else begin
          pend_l    <= enc_pend;
          pcount    <= tot[PCNT_W-1:0];
          bit_total <= bit_total_next;
          cnt       <= enc_cnt;
        end
      end else if (emit) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      sr      <= a_flush ? flush_sr : enc_sr;
      b_vbits <= a_flush ? VBITS_W'(pcount) : VBITS_W'(BYTE_W);
    end else if (emit) begin
      sr <= sr << BYTE_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_data.packed_byte <= sr[SR_W-1 -: BYTE_W];
      o_data.valid_bits  <= b_vbits;
      o_data.last_of_run <= cnt == CNT_W'(1);
      o_data.total_bits  <= bit_total;
    end
  end

  assign result.valid = o_valid;
  assign result.data  = o_data;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(SLOTS))
    else $error("byte count beyond accumulator size");

  a_pend_clean: assert property (@(posedge clk) disable iff (rst)
    (pend_l << pcount) == '0)
    else $error("stale bits below pending count");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    a_go && a_flush |=> pcount == '0)
    else $error("flush left pending bits");

  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    a_go |=> bit_total >= $past(bit_total))
    else $error("bit total decreased");

endmodule

@@ tb/tb_huffman_code_bit_packer.sv @@
`timescale 1ns / 100ps

module tb_huffman_code_bit_packer;
  import hcbp_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int MAX_LEN = 32;
  localparam int FULL_BYTE = 8;
  localparam int TABLE_SIZE = 256;
  localparam int SENDER_IDLE_PCT = 71;
  localparam int RECEIVER_STALL_PCT = 71;
  localparam int BOTH_IDLE_PCT = 37;
  localparam int PHASE_WORDS = 46;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOW_LIMIT = 10;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    item_t      w;
    bit         drain;
    idle_mode_t mode;
  } stim_entry_t;

  logic clk;
  logic rst;

  hcbp_item_if   item_ch ();
  hcbp_result_if result_ch ();

  huffman_code_bit_packer DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  stim_entry_t stim_words[$];
  result_t     byte_forecast[$];
  logic [7:0]  coded_syms[$];
  idle_mode_t  gen_mode;
  idle_mode_t  cur_mode;
  bit          item_taken;
  int          fault_count;
  int          cycle_count;

  // predictor state
  logic [31:0] code_tbl [TABLE_SIZE];
  logic [5:0]  len_tbl [TABLE_SIZE];
  logic [6:0]  acc_bits;
  logic [2:0]  acc_count;
  logic [31:0] bits_sent;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic pack_word(input item_t w);
    logic [5:0]  len;
    logic [31:0] code;
    logic [7:0]  acc;
    logic [32:0] sum;
    int          n;
    int          j;
    bit          held;
    result_t     prev;
    held = 1'b0;
    prev = '0;
    case (w.cmd)
      CMD_LOAD: begin
        len = (w.code_length > MAX_LEN) ? 6'(MAX_LEN) : w.code_length;
        code_tbl[w.symbol] = w.code_bits;
        len_tbl[w.symbol] = len;
      end
      CMD_ENCODE: begin
        len = len_tbl[w.symbol];
        code = code_tbl[w.symbol];
        if (len != 0) begin
          sum = {1'b0, bits_sent} + len;
          bits_sent = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          acc = {1'b0, acc_bits};
          n = acc_count;
          for (j = len; j > 0; j--) begin
            acc = {acc[6:0], code[j-1]};
            n++;
            if (n == FULL_BYTE) begin
              if (held) byte_forecast.push_back(prev);
              prev.packed_byte = acc;
              prev.valid_bits = 4'(FULL_BYTE);
              prev.last_of_run = 1'b0;
              prev.total_bits = bits_sent;
              held = 1'b1;
              acc = '0;
              n = 0;
            end
          end
          acc_bits = acc[6:0];
          acc_count = 3'(n);
          if (held) begin
            prev.last_of_run = 1'b1;
            byte_forecast.push_back(prev);
          end
        end
      end
      CMD_FLUSH: begin
        if (acc_count != 0) begin
          prev.packed_byte = {1'b0, acc_bits} << (FULL_BYTE - acc_count);
          prev.valid_bits = 4'(acc_count);
          prev.last_of_run = 1'b1;
          prev.total_bits = bits_sent;
          byte_forecast.push_back(prev);
          acc_bits = '0;
          acc_count = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_word(input logic [1:0] cmd, input logic [7:0] sym,
                            input logic [31:0] bits, input logic [5:0] len,
                            input bit drain);
    stim_entry_t e;
    e.w.cmd = cmd;
    e.w.symbol = sym;
    e.w.code_bits = bits;
    e.w.code_length = len;
    e.drain = drain;
    e.mode = gen_mode;
    stim_words.push_back(e);
    if (cmd == CMD_LOAD && len != 0) coded_syms.push_back(sym);
  endtask

  // driver
  always @(negedge clk) begin : drive_words
    stim_entry_t head;
    bit          idle;
    if (!rst) begin
      if (!item_ch.valid || item_taken) begin
        idle = 1'b1;
        if (stim_words.size() > 0) begin
          head = stim_words[0];
          idle = (head.drain && byte_forecast.size() != 0) ||
                 (head.mode == IDLE_SENDER && $urandom_range(0, 99) < SENDER_IDLE_PCT) ||
                 (head.mode == IDLE_BOTH && $urandom_range(0, 99) < BOTH_IDLE_PCT);
        end
        if (!idle) begin
          head = stim_words.pop_front();
          item_ch.data <= head.w;
          item_ch.valid <= 1'b1;
          cur_mode <= head.mode;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
      case (cur_mode)
        IDLE_RECEIVER: result_ch.ready <= $urandom_range(0, 99) >= RECEIVER_STALL_PCT;
        IDLE_BOTH:     result_ch.ready <= $urandom_range(0, 99) >= BOTH_IDLE_PCT;
        default:       result_ch.ready <= 1'b1;
      endcase
    end
  end

  // monitor and checker
  always @(posedge clk) begin : watch_bytes
    result_t want;
    result_t got;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= item_ch.valid && item_ch.ready;
      if (item_ch.valid && item_ch.ready) pack_word(item_ch.data);
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        if (byte_forecast.size() == 0) begin
          fault_count++;
          if (fault_count <= SHOW_LIMIT)
            $display("unexpected byte %h bits %0d last %0d total %0d",
                     got.packed_byte, got.valid_bits, got.last_of_run, got.total_bits);
        end else begin
          want = byte_forecast.pop_front();
          if (got.packed_byte !== want.packed_byte || got.valid_bits !== want.valid_bits ||
              got.last_of_run !== want.last_of_run || got.total_bits !== want.total_bits) begin
            fault_count++;
            if (fault_count <= SHOW_LIMIT)
              $display("mismatch byte/bits/last/total: want %h/%0d/%0d/%0d, got %h/%0d/%0d/%0d",
                       want.packed_byte, want.valid_bits, want.last_of_run, want.total_bits,
                       got.packed_byte, got.valid_bits, got.last_of_run, got.total_bits);
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin : run_test
    int          p;
    int          k;
    int          r;
    int          r2;
    logic [5:0]  len;
    logic [7:0]  sym;
    clk = 1'b0;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    result_ch.ready = 1'b0;
    item_taken = 1'b0;
    fault_count = 0;
    cycle_count = 0;
    cur_mode = IDLE_NONE;
    gen_mode = IDLE_NONE;
    for (k = 0; k < TABLE_SIZE; k++) begin
      code_tbl[k] = '0;
      len_tbl[k] = '0;
    end
    acc_bits = '0;
    acc_count = '0;
    bits_sent = '0;

    // directed words
    queue_word(CMD_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);
    queue_word(CMD_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0);
    queue_word(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 1'b0);
    queue_word(CMD_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd1, 1'b0);
    queue_word(CMD_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b0);
    queue_word(CMD_LOAD, 8'h01, 32'h0000_0000, 6'd32, 1'b0);
    queue_word(CMD_LOAD, 8'h02, 32'hA5A5_A5A5, 6'd5, 1'b0);
    queue_word(CMD_LOAD, 8'h03, 32'h0000_005A, 6'd8, 1'b0);
    queue_word(CMD_LOAD, 8'h04, 32'hDEAD_BEEF, 6'd33, 1'b0);
    queue_word(CMD_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0);
    queue_word(CMD_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);
    queue_word(CMD_ENCODE, 8'hFF, 32'h0, 6'd0, 1'b0);
    queue_word(CMD_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0);
    queue_word(CMD_ENCODE, 8'hFF, 32'h0, 6'd0, 1'b0);
    queue_word(CMD_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0);
    queue_word(CMD_ENCODE, 8'h02, 32'h0, 6'd0, 1'b0);
    queue_word(CMD_ENCODE, 8'h03, 32'h0, 6'd0, 1'b0);
    queue_word(CMD_ENCODE, 8'h04, 32'h0, 6'd0, 1'b0);
    queue_word(CMD_LOAD, 8'h02, 32'h0000_001F, 6'd0, 1'b0);
    queue_word(CMD_ENCODE, 8'h02, 32'h0, 6'd0, 1'b0);
    queue_word(CMD_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);
    queue_word(CMD_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);
    queue_word(CMD_LOAD, 8'h05, 32'h0000_007F, 6'd7, 1'b0);
    queue_word(CMD_ENCODE, 8'h05, 32'h0, 6'd0, 1'b0);
    queue_word(CMD_ENCODE, 8'hFF, 32'h0, 6'd0, 1'b0);
    queue_word(CMD_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0);

    // random phases, one per idle mode, each opening after a full drain
    for (p = 0; p < 4; p++) begin
      gen_mode = idle_mode_t'(p);
      for (k = 0; k < PHASE_WORDS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          r2 = $urandom_range(0, 99);
          if (r2 < 80) len = 6'($urandom_range(1, 16));
          else if (r2 < 92) len = 6'($urandom_range(17, 32));
          else if (r2 < 96) len = 6'd0;
          else len = 6'($urandom_range(33, 63));
          if (coded_syms.size() > 0 && $urandom_range(0, 3) == 0)
            sym = coded_syms[$urandom_range(0, coded_syms.size() - 1)];
          else
            sym = 8'($urandom_range(0, 255));
          queue_word(CMD_LOAD, sym, $urandom, len, k == 0);
        end else if (r < 85) begin
          sym = coded_syms[$urandom_range(0, coded_syms.size() - 1)];
          queue_word(CMD_ENCODE, sym, $urandom, 6'($urandom_range(0, 63)), k == 0);
        end else if (r < 93) begin
          queue_word(CMD_FLUSH, 8'($urandom_range(0, 255)), $urandom,
                     6'($urandom_range(0, 63)), k == 0);
        end else if (r < 97) begin
          queue_word(CMD_ENCODE, 8'($urandom_range(0, 255)), $urandom,
                     6'($urandom_range(0, 63)), k == 0);
        end else begin
          queue_word(CMD_UNUSED, 8'($urandom_range(0, 255)), $urandom,
                     6'($urandom_range(0, 63)), k == 0);
        end
      end
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (stim_words.size() != 0 || item_ch.valid) @(posedge clk);
    while (byte_forecast.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (byte_forecast.size() != 0) fault_count++;

    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
